// File: rtl/core/smfs_pkg.sv
package smfs_pkg;

  localparam int BYTE_W        = 8;
  localparam int FRAME_LEN_DEF = 8;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_START_BYTE  = 1'b0,
    REG_MARKER_BYTE = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic append;
    logic shift;
    logic dec_fill;
    logic clear_fill;
    logic cnt_inc;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_start;
    logic last_slot;
    logic marker_ok;
    logic head_ok;
    logic next_is_start;
    logic fill_is_two;
    logic emit_last;
  } status_t;

endpackage

// File: rtl/core/smfs_rx_if.sv
interface smfs_rx_if;
  logic                      valid;
  logic                      ready;
  logic [smfs_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/smfs_frame_if.sv
interface smfs_frame_if;
  logic                      valid;
  logic                      ready;
  logic [smfs_pkg::BYTE_W-1:0] frame_byte;
  logic                      frame_end;
  logic                      locked;

  modport source (output valid, output frame_byte, output frame_end, output locked,
                  input ready);
  modport sink (input valid, input frame_byte, input frame_end, input locked,
                output ready);
endinterface

// File: rtl/core/smfs_cfg_if.sv
interface smfs_cfg_if;
  logic                      valid;
  logic                      ready;
  smfs_pkg::cfg_reg_t        index;
  logic [smfs_pkg::BYTE_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/smfs_datapath.sv
module smfs_datapath #(
  parameter int FRAME_LEN = smfs_pkg::FRAME_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [smfs_pkg::BYTE_W-1:0] rx_byte,
  input  logic                        cfg_we,
  input  smfs_pkg::cfg_reg_t          cfg_index,
  input  logic [smfs_pkg::BYTE_W-1:0] cfg_data,
  input  smfs_pkg::cmd_t              cmd,
  output smfs_pkg::status_t           status,
  output logic [smfs_pkg::BYTE_W-1:0] frame_byte,
  output logic                        frame_end
);

  localparam int CW = $clog2(FRAME_LEN + 1);
  localparam int IW = $clog2(FRAME_LEN);

  logic [smfs_pkg::BYTE_W-1:0] start_byte;
  logic [smfs_pkg::BYTE_W-1:0] marker_byte;
  logic [smfs_pkg::BYTE_W-1:0] store [FRAME_LEN];
  logic [CW-1:0]               fill;
  logic [CW-1:0]               fill_next;
  logic [IW-1:0]               cnt;
  logic [IW-1:0]               cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte  <= '0;
      marker_byte <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        smfs_pkg::REG_START_BYTE:  start_byte  <= cfg_data;
        smfs_pkg::REG_MARKER_BYTE: marker_byte <= cfg_data;
      endcase
    end
  end

  // The buffer shifts toward entry 0 for both the rescan and the frame output.
  always_ff @(posedge clk) begin
    for (int k = 0; k < FRAME_LEN; k++) begin
      if (cmd.shift) begin
        if (k < FRAME_LEN - 1) begin
          store[k] <= store[k+1];
        end
      end else if (cmd.append && fill[IW-1:0] == IW'(k)) begin
        store[k] <= rx_byte;
      end
    end
  end

  always_comb begin
    priority if (cmd.clear_fill) begin
      fill_next = '0;
    end else if (cmd.append) begin
      fill_next = fill + CW'(1);
    end else if (cmd.dec_fill) begin
      fill_next = fill - CW'(1);
    end else begin
      fill_next = fill;
    end
    if (cmd.cnt_inc) begin
      cnt_next = status.emit_last ? '0 : cnt + IW'(1);
    end else begin
      cnt_next = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      cnt  <= '0;
    end else begin
      fill <= fill_next;
      cnt  <= cnt_next;
    end
  end

  assign status.is_start      = (rx_byte == start_byte);
  assign status.last_slot     = (fill == CW'(FRAME_LEN - 1));
  assign status.marker_ok     = (store[FRAME_LEN-2] == marker_byte);
  assign status.head_ok       = (store[0] == start_byte);
  assign status.next_is_start = (store[1] == start_byte);
  assign status.fill_is_two   = (fill == CW'(2));
  assign status.emit_last     = (cnt == IW'(FRAME_LEN - 1));

  assign frame_byte = store[0];
  assign frame_end  = status.emit_last;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(FRAME_LEN))
    else $error("buffer fill count beyond frame length");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> fill < CW'(FRAME_LEN))
    else $error("byte written into a full buffer");

  a_emit_from_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.cnt_inc && status.emit_last) |=> cnt == '0)
    else $error("output counter did not wrap after the last frame byte");

endmodule

// File: rtl/core/smfs_ctrl.sv
module smfs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              locked,
  input  smfs_pkg::status_t status,
  output smfs_pkg::cmd_t    cmd
);

  smfs_pkg::state_t state;
  smfs_pkg::state_t state_next;
  logic             in_lock;
  logic             in_lock_next;
  logic             start_seen;
  logic             start_seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= smfs_pkg::ST_IDLE;
      in_lock    <= 1'b0;
      start_seen <= 1'b0;
    end else begin
      state      <= state_next;
      in_lock    <= in_lock_next;
      start_seen <= start_seen_next;
    end
  end

  always_comb begin
    state_next      = state;
    in_lock_next    = in_lock;
    start_seen_next = start_seen;
    cmd             = '0;
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    unique case (state)
      smfs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_lock && !start_seen) begin
            // Hunting: only a start byte opens a new frame.
            if (status.is_start) begin
              cmd.append      = 1'b1;
              start_seen_next = 1'b1;
            end
          end else begin
            cmd.append = 1'b1;
            if (status.last_slot) begin
              if (!in_lock) begin
                if (status.marker_ok) begin
                  cmd.clear_fill  = 1'b1;
                  in_lock_next    = 1'b1;
                  start_seen_next = 1'b0;
                  state_next      = smfs_pkg::ST_EMIT;
                end else begin
                  state_next = smfs_pkg::ST_SCAN;
                end
              end else begin
                cmd.clear_fill = 1'b1;
                if (status.head_ok && status.marker_ok) begin
                  state_next = smfs_pkg::ST_EMIT;
                end else begin
                  in_lock_next    = 1'b0;
                  start_seen_next = 1'b0;
                end
              end
            end
          end
        end
      end
      smfs_pkg::ST_SCAN: begin
        // Drop the head byte each cycle until a start byte leads the buffer; if none is found, clear it.
        if (status.next_is_start) begin
          cmd.shift       = 1'b1;
          cmd.dec_fill    = 1'b1;
          start_seen_next = 1'b1;
          state_next      = smfs_pkg::ST_IDLE;
        end else if (status.fill_is_two) begin
          cmd.clear_fill  = 1'b1;
          start_seen_next = 1'b0;
          state_next      = smfs_pkg::ST_IDLE;
        end else begin
          cmd.shift    = 1'b1;
          cmd.dec_fill = 1'b1;
        end
      end
      smfs_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.shift   = 1'b1;
          cmd.cnt_inc = 1'b1;
          if (status.emit_last) begin
            state_next = smfs_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = smfs_pkg::ST_IDLE;
      end
    endcase
  end

  assign locked = in_lock;

  a_emit_locked: assert property (@(posedge clk) disable iff (rst)
    state == smfs_pkg::ST_EMIT |-> in_lock)
    else $error("frame output while not locked");

  a_scan_hunting: assert property (@(posedge clk) disable iff (rst)
    state == smfs_pkg::ST_SCAN |-> (!in_lock && start_seen))
    else $error("rescan outside of hunting with a buffered start");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.shift && cmd.append))
    else $error("buffer shift and write in the same cycle");

endmodule

// File: rtl/core/start_marker_frame_sync_core.sv
// A byte that does not complete a frame leaves the core ready for the next byte.
// A byte that completes a good frame starts FRAME_LEN output items, one per cycle
// while the sink is ready; the next byte is accepted after the last one is taken.
// A marker mismatch while hunting starts a rescan of the buffer, one byte per
// cycle, during which no input byte is accepted.
// Reset clears control state and configuration; the frame buffer is not cleared.
module start_marker_frame_sync_core #(
  parameter int FRAME_LEN = smfs_pkg::FRAME_LEN_DEF
) (
  input  logic         clk,
  input  logic         rst,
  smfs_rx_if.sink      rx,
  smfs_frame_if.source frame,
  smfs_cfg_if.sink     cfg
);

  smfs_pkg::cmd_t    cmd;
  smfs_pkg::status_t status;

  assign cfg.ready = 1'b1;

  smfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .out_valid (frame.valid),
    .out_ready (frame.ready),
    .locked    (frame.locked),
    .status    (status),
    .cmd       (cmd)
  );

  smfs_datapath #(
    .FRAME_LEN (FRAME_LEN)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .rx_byte    (rx.rx_byte),
    .cfg_we     (cfg.valid && cfg.ready),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .cmd        (cmd),
    .status     (status),
    .frame_byte (frame.frame_byte),
    .frame_end  (frame.frame_end)
  );

endmodule
